@@ sv/lpd_pkg.sv @@
`default_nettype none
package lpd_pkg;

	localparam int unsigned LENGTH_WIDTH_DEF = 27;
	localparam int unsigned HEADER_LEN       = 4;
	localparam logic [32:0] FRAME_CAP        = 33'h0_0400_0000;

endpackage
`default_nettype wire

@@ sv/lpd_in_if.sv @@
`default_nettype none
interface lpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

@@ sv/lpd_out_if.sv @@
`default_nettype none
interface lpd_out_if
	import lpd_pkg::*;
#(
	parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
);
	logic                    valid;
	logic                    ready;
	logic [7:0]              payload_byte;
	logic                    first_of_message;
	logic                    last_of_message;
	logic [LENGTH_WIDTH-1:0] message_length;
	logic                    error;

	modport source (
		output valid, output payload_byte, output first_of_message,
		output last_of_message, output message_length, output error,
		input ready
	);
	modport sink (
		input valid, input payload_byte, input first_of_message,
		input last_of_message, input message_length, input error,
		output ready
	);
endinterface
`default_nettype wire

@@ sv/length_prefix_deframer.sv @@
// Length-prefixed message deframer.
// stream: one byte per transfer. Each message is a 4-byte big-endian length
//   header followed by that many payload bytes. Header bytes give no result unless in error (below).
// result: one transfer per payload byte, with first/last marks and the
//   message length. A header of zero or above the cap (the smaller of
//   max_length and 64 Mi) sets a sticky error; that byte and every later one
//   gives a result with error set and all other fields zero.
// max_length_we / max_length: cap register; the user must write it only while idle, the block does not enforce it.
// Throughput: one byte per cycle while result.ready is high. Each byte is decoded in the cycle it is
//   taken, against the framing state registers; its result sits in the
//   output register from the next cycle on.
// Stall: stream.ready follows "output register empty or being drained", so
//   a stalled receiver holds the byte stream off with no loss.
// Reset (arst_n low): framing state and error clear, cap returns to 64 Mi
//   (truncated to LENGTH_WIDTH), output register empties. No clearing pass.
`default_nettype none
module length_prefix_deframer
	import lpd_pkg::*;
#(
	parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    max_length_we,
	input  wire logic [LENGTH_WIDTH-1:0] max_length,
	lpd_in_if.sink                       stream,
	lpd_out_if.source                    result
);

	localparam logic [1:0] LAST_HDR = 2'(HEADER_LEN - 1);
	localparam logic [LENGTH_WIDTH-1:0] CAP_RESET = LENGTH_WIDTH'(FRAME_CAP);

	logic [LENGTH_WIDTH-1:0] max_length_q;
	logic [23:0]             header_q;
	logic [1:0]              hcnt_q;
	logic                    in_payload_q;
	logic [LENGTH_WIDTH-1:0] cur_q;
	logic [LENGTH_WIDTH-1:0] rem_q;
	logic                    err_q;

	logic                    valid_q;
	logic [7:0]              byte_q;
	logic                    first_q;
	logic                    last_q;
	logic [LENGTH_WIDTH-1:0] len_q;
	logic                    oerr_q;

	logic        take;
	logic [32:0] hdr_len;
	logic        bad_len;
	logic [LENGTH_WIDTH-1:0] rem_dec;

	assign stream.ready = !valid_q || result.ready;
	assign take         = stream.valid && stream.ready;
	assign hdr_len      = {1'b0, header_q, stream.data_byte};
	assign bad_len      = (hdr_len == '0) || (hdr_len > FRAME_CAP)
	                      || (hdr_len > 33'(max_length_q));
	assign rem_dec      = rem_q - LENGTH_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= CAP_RESET;
		end else if (max_length_we) begin
			max_length_q <= max_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= '0;
			hcnt_q       <= '0;
			in_payload_q <= 1'b0;
			cur_q        <= '0;
			rem_q        <= '0;
			err_q        <= 1'b0;
		end else if (take && !err_q) begin
			if (in_payload_q) begin
				rem_q <= rem_dec;
				if (rem_dec == '0) begin
					in_payload_q <= 1'b0;
					cur_q        <= '0;
				end
			end else if (hcnt_q != LAST_HDR) begin
				header_q <= {header_q[15:0], stream.data_byte};
				hcnt_q   <= hcnt_q + 2'd1;
			end else begin
				header_q <= '0;
				hcnt_q   <= '0;
				if (bad_len) begin
					err_q <= 1'b1;
				end else begin
					in_payload_q <= 1'b1;
					cur_q        <= LENGTH_WIDTH'(hdr_len);
					rem_q        <= LENGTH_WIDTH'(hdr_len);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= err_q || in_payload_q || (hcnt_q == LAST_HDR && bad_len);
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (err_q || (!in_payload_q && hcnt_q == LAST_HDR && bad_len)) begin
				byte_q  <= '0;
				first_q <= 1'b0;
				last_q  <= 1'b0;
				len_q   <= '0;
				oerr_q  <= 1'b1;
			end else begin
				byte_q  <= stream.data_byte;
				first_q <= (rem_q == cur_q);
				last_q  <= (rem_q == LENGTH_WIDTH'(1));
				len_q   <= cur_q;
				oerr_q  <= 1'b0;
			end
		end
	end

	assign result.valid            = valid_q;
	assign result.payload_byte     = byte_q;
	assign result.first_of_message = first_q;
	assign result.last_of_message  = last_q;
	assign result.message_length   = len_q;
	assign result.error            = oerr_q;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("sticky error cleared");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (rem_q != '0) && (rem_q <= cur_q) && (hcnt_q == '0))
		else $error("payload counter out of range");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && oerr_q) |-> (byte_q == '0) && (len_q == '0) && !first_q && !last_q)
		else $error("error result carries data");

	a_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && first_q && last_q) |-> (len_q == LENGTH_WIDTH'(1)))
		else $error("first and last on a multi-byte message");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && err_q) |=> (valid_q && oerr_q))
		else $error("byte after error gave no error result");

endmodule
`default_nettype wire

@@ tb/sv/length_prefix_deframer_tb.sv @@
`timescale 1ns / 100ps
module length_prefix_deframer_tb;
	import lpd_pkg::*;

	localparam int unsigned LW           = LENGTH_WIDTH_DEF;
	localparam logic [31:0] CAP_LIMIT    = FRAME_CAP[31:0];
	localparam logic [31:0] LEN_ALL_ONES = (32'd1 << LW) - 32'd1;
	localparam int unsigned ITEM_TARGET  = 1650;

	typedef enum logic [1:0] {CMD_BYTE, CMD_DRAIN, CMD_CFG, CMD_RX_PACE} link_kind_t;

	typedef struct {
		link_kind_t  kind;
		logic [31:0] value;
		int unsigned gap;
	} link_cmd_t;

	typedef struct packed {
		logic [7:0]    payload_byte;
		logic          first_of_message;
		logic          last_of_message;
		logic [LW-1:0] message_length;
		logic          error;
	} frame_res_t;

	logic          clk;
	logic          arst_n;
	logic          max_length_we;
	logic [LW-1:0] max_length;

	lpd_in_if                      stream_if ();
	lpd_out_if #(.LENGTH_WIDTH(LW)) result_if ();

	length_prefix_deframer #(.LENGTH_WIDTH(LW)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_length_we (max_length_we),
		.max_length    (max_length),
		.stream        (stream_if),
		.result        (result_if)
	);

	link_cmd_t   link_script[$];
	frame_res_t  awaited_results[$];
	int unsigned bytes_queued = 0;
	int unsigned tx_gap_max = 0;
	int unsigned rx_gap_max = 0;
	int unsigned fail_count = 0;

	// deframer state as seen from outside
	logic [LW-1:0] cap_reg = FRAME_CAP[LW-1:0];
	logic [23:0]   hdr_acc = '0;
	logic [1:0]    hdr_cnt = '0;
	logic          in_msg = 1'b0;
	logic [LW-1:0] msg_len = '0;
	logic [LW-1:0] msg_left = '0;
	logic          err_seen = 1'b0;

	// handshake bookkeeping between the rising and falling clock edges
	bit          stream_fire = 1'b0;
	bit          result_fire = 1'b0;
	bit          gap_loaded = 1'b0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned rx_wait = 0;
	logic        nxt_valid;
	logic        nxt_we;
	frame_res_t  want;
	frame_res_t  pred;

	function automatic bit deframe_byte(input logic [7:0] b, output frame_res_t r);
		logic [31:0] hdr;
		logic [32:0] eff;
		r = '0;
		if (err_seen) begin
			r.error = 1'b1;
			return 1'b1;
		end
		if (in_msg) begin
			r.payload_byte     = b;
			r.first_of_message = (msg_left == msg_len);
			r.last_of_message  = (msg_left == LW'(1));
			r.message_length   = msg_len;
			msg_left           = msg_left - 1'b1;
			if (msg_left == '0) begin
				in_msg  = 1'b0;
				msg_len = '0;
			end
			return 1'b1;
		end
		if (hdr_cnt != 2'd3) begin
			hdr_acc = {hdr_acc[15:0], b};
			hdr_cnt = hdr_cnt + 1'b1;
			return 1'b0;
		end
		hdr     = {hdr_acc, b};
		hdr_acc = '0;
		hdr_cnt = '0;
		eff     = {{(33 - LW){1'b0}}, cap_reg};
		if (eff > FRAME_CAP)
			eff = FRAME_CAP;
		if (hdr == '0 || {1'b0, hdr} > eff) begin
			err_seen = 1'b1;
			r.error  = 1'b1;
			return 1'b1;
		end
		in_msg   = 1'b1;
		msg_len  = hdr[LW-1:0];
		msg_left = hdr[LW-1:0];
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			fail_count++;
		end
	endtask

	task automatic queue_cmd(input link_kind_t kind, input logic [31:0] value);
		link_cmd_t c;
		c.kind  = kind;
		c.value = value;
		c.gap   = (kind == CMD_BYTE) ? $urandom_range(0, tx_gap_max) : 0;
		link_script.push_back(c);
		if (kind == CMD_BYTE)
			bytes_queued++;
	endtask

	task automatic queue_byte(input logic [7:0] b);
		queue_cmd(CMD_BYTE, {24'd0, b});
	endtask

	task automatic queue_header(input logic [31:0] len);
		for (int i = 3; i >= 0; i--)
			queue_byte(len[8*i +: 8]);
	endtask

	task automatic queue_random_message(input int unsigned len);
		queue_header(len);
		for (int unsigned i = 0; i < len; i++)
			queue_byte($urandom_range(0, 255));
	endtask

	// wait for all results, let the block settle, then write the cap
	task automatic queue_setting(input logic [31:0] value);
		queue_cmd(CMD_DRAIN, 32'd4);
		queue_cmd(CMD_CFG, value);
	endtask

	function automatic int unsigned pick_gap_max();
		int unsigned p;
		p = $urandom_range(0, 2);
		return (p == 0) ? 0 : (p == 1) ? 3 : 15;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				result_fire = 1'b1;
				if (awaited_results.size() == 0) begin
					$error("result transfer with none expected");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("payload_byte", 32'(want.payload_byte),
						32'(result_if.payload_byte));
					check_field("first_of_message", 32'(want.first_of_message),
						32'(result_if.first_of_message));
					check_field("last_of_message", 32'(want.last_of_message),
						32'(result_if.last_of_message));
					check_field("message_length", 32'(want.message_length),
						32'(result_if.message_length));
					check_field("error", 32'(want.error), 32'(result_if.error));
				end
			end
			if (stream_if.valid && stream_if.ready) begin
				stream_fire = 1'b1;
				if (deframe_byte(stream_if.data_byte, pred))
					awaited_results.push_back(pred);
			end
			if (max_length_we)
				cap_reg = max_length;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_fire) begin
				result_fire = 1'b0;
				rx_wait     = $urandom_range(0, rx_gap_max);
			end
			if (rx_wait != 0) begin
				rx_wait--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end

			if (!stream_if.valid || stream_fire) begin
				stream_fire = 1'b0;
				nxt_valid   = 1'b0;
				nxt_we      = 1'b0;
				if (hold_left != 0) begin
					hold_left--;
				end else if (link_script.size() != 0) begin
					case (link_script[0].kind)
						CMD_BYTE: begin
							if (!gap_loaded) begin
								gap_left   = link_script[0].gap;
								gap_loaded = 1'b1;
							end
							if (gap_left != 0) begin
								gap_left--;
							end else begin
								nxt_valid = 1'b1;
								stream_if.data_byte <= link_script[0].value[7:0];
								gap_loaded = 1'b0;
								void'(link_script.pop_front());
							end
						end
						CMD_DRAIN: begin
							if (awaited_results.size() == 0) begin
								hold_left = link_script[0].value;
								void'(link_script.pop_front());
							end
						end
						CMD_CFG: begin
							nxt_we = 1'b1;
							max_length <= link_script[0].value[LW-1:0];
							void'(link_script.pop_front());
						end
						CMD_RX_PACE: begin
							rx_gap_max = link_script[0].value;
							void'(link_script.pop_front());
						end
					endcase
				end
				stream_if.valid <= nxt_valid;
				max_length_we   <= nxt_we;
			end
		end
	end

	initial begin
		int unsigned cap_val, eff, len, upper, n_msgs, pick, err_kind;
		logic [31:0] hdr;

		arst_n              = 1'b0;
		max_length_we       = 1'b0;
		max_length          = '0;
		stream_if.valid     = 1'b0;
		stream_if.data_byte = '0;
		result_if.ready     = 1'b0;

		// directed: one-byte messages, byte extremes, cap of one, widest cap
		queue_header(32'd1);
		queue_byte(8'hFF);
		queue_header(32'd3);
		queue_byte(8'h00);
		queue_byte(8'hA5);
		queue_byte(8'h5A);
		queue_setting(32'd1);
		queue_header(32'd1);
		queue_byte(8'h80);
		queue_setting(LEN_ALL_ONES);
		queue_header(32'd2);
		queue_byte(8'h01);
		queue_byte(8'hFE);

		while (bytes_queued < ITEM_TARGET - 40) begin
			pick = $urandom_range(0, 5);
			case (pick)
				0: cap_val = 1;
				1: cap_val = $urandom_range(2, 16);
				2: cap_val = $urandom_range(17, 700);
				3: cap_val = CAP_LIMIT;
				4: cap_val = LEN_ALL_ONES;
				default: cap_val = $urandom_range(CAP_LIMIT + 1, LEN_ALL_ONES - 1);
			endcase
			eff = (cap_val > CAP_LIMIT) ? CAP_LIMIT : cap_val;
			queue_setting(cap_val);
			queue_cmd(CMD_RX_PACE, pick_gap_max());
			tx_gap_max = pick_gap_max();
			n_msgs = $urandom_range(2, 10);
			for (int unsigned m = 0; m < n_msgs && bytes_queued < ITEM_TARGET - 40; m++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0 && eff <= 700)
					len = eff;
				else if (pick == 1 && eff >= 256)
					len = $urandom_range(256, (eff < 600) ? eff : 600);
				else begin
					upper = (eff < 24) ? eff : 24;
					len   = $urandom_range(1, upper);
				end
				queue_random_message(len);
				if ($urandom_range(0, 7) == 0)
					queue_cmd(CMD_DRAIN, 32'd0);
			end
		end

		// the error is sticky until reset, so one violation closes the run
		queue_cmd(CMD_RX_PACE, pick_gap_max());
		tx_gap_max = pick_gap_max();
		err_kind = $urandom_range(0, 3);
		case (err_kind)
			0: begin
				queue_setting($urandom_range(1, CAP_LIMIT));
				hdr = 32'd0;
			end
			1: begin
				cap_val = $urandom_range(1, 200);
				queue_setting(cap_val);
				queue_random_message(cap_val);
				hdr = $urandom_range(0, 1) ? cap_val + 1 : $urandom_range(cap_val + 1, 32'hFFFF_FFFF);
			end
			2: begin
				queue_setting(32'd0);
				hdr = $urandom;
			end
			default: begin
				queue_setting(LEN_ALL_ONES);
				hdr = $urandom_range(0, 1) ? CAP_LIMIT + 1 :
					$urandom_range(CAP_LIMIT + 1, 32'hFFFF_FFFF);
			end
		endcase
		queue_header(hdr);
		queue_header(32'd2);
		n_msgs = $urandom_range(12, 40);
		for (int unsigned i = 0; i < n_msgs; i++)
			queue_byte($urandom_range(0, 255));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (link_script.size() != 0 || stream_if.valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
